[hw/rtl/pht_pkg.sv]
// ----------------------------------------------------------------------------
// pht_pkg: shared types and constants of the polygon hit test block
// Command and result beats, the decoded work item and the segment unit result.
// ----------------------------------------------------------------------------
package pht_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_QUERY = 2'd2;

  // Squared distance width and root width; DSQ_W must stay even.
  localparam int DSQ_W  = 36;
  localparam int ROOT_W = 18;
  localparam logic [16:0] DIST_MAX = 17'h1FFFF;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
    logic               starts_loop;
    logic               loop_is_closed;
    logic [14:0]        pad;
  } cmd_t;

  typedef struct packed {
    logic        status;
    logic        inside_res;
    logic        near;
    logic [16:0] distance;
    logic        no_outline;
  } res_t;

  typedef enum logic [1:0] {OP_CLEAR, OP_ADD, OP_QUERY, OP_NOP} op_t;

  typedef struct packed {
    op_t                op;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               starts;
    logic               closed;
    logic [14:0]        pad;
  } item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } pt_t;

  typedef struct packed {
    logic             done;
    logic             toggle;
    logic [DSQ_W-1:0] dsq;
  } seg_res_t;

endpackage

[hw/rtl/pht_ram.sv]
// ----------------------------------------------------------------------------
// pht_ram: generic single write port, single read port RAM
// Read data is registered and follows the address in the next cycle.
// ----------------------------------------------------------------------------
module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/pht_front.sv]
// ----------------------------------------------------------------------------
// pht_front: command intake
// Decodes each command beat into a work item and holds it in a two entry queue.
// ----------------------------------------------------------------------------
module pht_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  pht_pkg::cmd_t   cmd,
  output logic            item_valid,
  output pht_pkg::item_t  item,
  input  logic            item_pop
);

  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  pht_pkg::item_t slots [2];
  pht_pkg::item_t new_item;
  logic           push;

  always_comb begin
    new_item.x      = cmd.coord_x;
    new_item.y      = cmd.coord_y;
    new_item.starts = cmd.starts_loop;
    new_item.closed = cmd.loop_is_closed;
    new_item.pad    = cmd.pad;
    unique case (cmd.func)
      pht_pkg::FUNC_CLEAR: new_item.op = pht_pkg::OP_CLEAR;
      pht_pkg::FUNC_ADD:   new_item.op = pht_pkg::OP_ADD;
      pht_pkg::FUNC_QUERY: new_item.op = pht_pkg::OP_QUERY;
      default:             new_item.op = pht_pkg::OP_NOP;
    endcase
  end

  assign busy       = (count == 2'd2);
  assign push       = start && !busy;
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (item_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(item_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_item;
    end
  end

endmodule

[hw/rtl/pht_seg.sv]
// ----------------------------------------------------------------------------
// pht_seg: one segment against the query point
// Squared distance by clamped projection and the even-odd crossing test,
// worked through a short sequence of multiply and divide steps.
// ----------------------------------------------------------------------------
module pht_seg (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  pht_pkg::pt_t      a,
  input  pht_pkg::pt_t      b,
  input  pht_pkg::pt_t      p,
  output pht_pkg::seg_res_t res
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MW, S_ML, S_MC, S_CMP, S_PLO, S_PHI, S_PACK,
    S_DIV, S_FIX, S_DIST, S_SQ, S_SUM
  } state_t;

  state_t state;
  logic   done_q;
  logic   tog;

  logic signed [15:0] ax, ay, bx, by, px, py;
  logic signed [16:0] abx, aby, wx, wy;
  logic               cr;
  logic signed [33:0] p1, p2;
  logic signed [34:0] num;
  logic [33:0]        len;
  logic [15:0]        mx, my;
  logic [32:0]        plx, ply;
  logic [31:0]        phx, phy;
  logic [49:0]        dvx, dvy;
  logic [15:0]        qtx, qty;
  logic [3:0]         i;
  logic signed [16:0] qx, qy;
  logic signed [17:0] dx, dy;
  logic [35:0]        s1, s2;
  logic [pht_pkg::DSQ_W-1:0] dsq;
  logic [49:0]        trial;

  assign trial = {16'b0, len} << i;

  assign res.done   = done_q;
  assign res.toggle = tog;
  assign res.dsq    = dsq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            ax <= a.x; ay <= a.y;
            bx <= b.x; by <= b.y;
            px <= p.x; py <= p.y;
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          abx <= 17'(bx) - 17'(ax);
          aby <= 17'(by) - 17'(ay);
          wx  <= 17'(px) - 17'(ax);
          wy  <= 17'(py) - 17'(ay);
          cr  <= (ay > py) != (by > py);
          state <= S_MW;
        end
        S_MW: begin
          p1 <= wx * abx;
          p2 <= wy * aby;
          state <= S_ML;
        end
        S_ML: begin
          num <= 35'(p1) + 35'(p2);
          p1  <= abx * abx;
          p2  <= aby * aby;
          state <= S_MC;
        end
        S_MC: begin
          len <= 34'(p1) + 34'(p2);
          p1  <= wx * aby;
          p2  <= wy * abx;
          state <= S_CMP;
        end
        S_CMP: begin
          // p1 and p2 now hold the two sides of the crossing compare.
          tog <= cr && ((aby > 0) ? (p1 < p2) : (p1 > p2));
          if (num <= 0) begin
            qx <= 17'(ax);
            qy <= 17'(ay);
            state <= S_DIST;
          end else if (num >= $signed({1'b0, len})) begin
            qx <= 17'(bx);
            qy <= 17'(by);
            state <= S_DIST;
          end else begin
            mx <= (abx < 0) ? 16'(-abx) : 16'(abx);
            my <= (aby < 0) ? 16'(-aby) : 16'(aby);
            state <= S_PLO;
          end
        end
        S_PLO: begin
          plx <= mx * num[16:0];
          ply <= my * num[16:0];
          state <= S_PHI;
        end
        S_PHI: begin
          phx <= mx * num[32:17];
          phy <= my * num[32:17];
          state <= S_PACK;
        end
        S_PACK: begin
          dvx <= 50'(plx) + (50'(phx) << 17);
          dvy <= 50'(ply) + (50'(phy) << 17);
          qtx <= 16'd0;
          qty <= 16'd0;
          i   <= 4'd15;
          state <= S_DIV;
        end
        S_DIV: begin
          // The quotient is below the delta magnitude, so sixteen bits do.
          if (dvx >= trial) begin
            dvx    <= dvx - trial;
            qtx[i] <= 1'b1;
          end
          if (dvy >= trial) begin
            dvy    <= dvy - trial;
            qty[i] <= 1'b1;
          end
          if (i == 4'd0) begin
            state <= S_FIX;
          end else begin
            i <= i - 4'd1;
          end
        end
        S_FIX: begin
          // Floor division: a negative quotient with a remainder rounds down.
          qx <= (abx < 0) ? 17'(ax) - 17'(qtx) - 17'(dvx != 50'd0) : 17'(ax) + 17'(qtx);
          qy <= (aby < 0) ? 17'(ay) - 17'(qty) - 17'(dvy != 50'd0) : 17'(ay) + 17'(qty);
          state <= S_DIST;
        end
        S_DIST: begin
          dx <= 18'(px) - 18'(qx);
          dy <= 18'(py) - 18'(qy);
          state <= S_SQ;
        end
        S_SQ: begin
          s1 <= dx * dx;
          s2 <= dy * dy;
          state <= S_SUM;
        end
        S_SUM: begin
          dsq    <= s1 + s2;
          done_q <= 1'b1;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/pht_isqrt.sv]
// ----------------------------------------------------------------------------
// pht_isqrt: floor integer square root
// Digit by digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module pht_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [pht_pkg::DSQ_W-1:0]   value,
  output logic                        done,
  output logic [pht_pkg::ROOT_W-1:0]  root
);

  typedef enum logic {R_IDLE, R_RUN} state_t;

  state_t                    state;
  logic [pht_pkg::DSQ_W-1:0] v;
  logic [pht_pkg::DSQ_W-1:0] res;
  logic [pht_pkg::DSQ_W-1:0] bitv;
  logic [pht_pkg::DSQ_W:0]   sum;

  assign sum  = {1'b0, res} + {1'b0, bitv};
  assign root = res[pht_pkg::ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        R_IDLE: begin
          if (go) begin
            v     <= value;
            res   <= '0;
            bitv  <= pht_pkg::DSQ_W'(1) << (pht_pkg::DSQ_W - 2);
            state <= R_RUN;
          end
        end
        R_RUN: begin
          if ({1'b0, v} >= sum) begin
            v   <= v - sum[pht_pkg::DSQ_W-1:0];
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          bitv <= bitv >> 2;
          if (bitv == pht_pkg::DSQ_W'(1)) begin
            done  <= 1'b1;
            state <= R_IDLE;
          end
        end
        default: state <= R_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/pht_back.sv]
// ----------------------------------------------------------------------------
// pht_back: table keeper and query walker
// Applies clear and add items to the vertex and loop tables, and walks every
// segment of every loop for a query, then takes the root of the best distance.
// ----------------------------------------------------------------------------
module pht_back #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_LOOPS    = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  pht_pkg::item_t  item,
  output logic            item_pop,
  output logic            done,
  output pht_pkg::res_t   result
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int VCW = $clog2(MAX_VERTICES + 1);
  localparam int LIW = (MAX_LOOPS > 1) ? $clog2(MAX_LOOPS) : 1;
  localparam int LCW = $clog2(MAX_LOOPS + 1);

  typedef struct packed {
    logic [VIW-1:0] first;
    logic [VCW-1:0] total;
    logic           closed;
  } loop_ent_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LREQ, B_LGET, B_VREQ, B_VGET, B_SEGW, B_ROOT, B_ROOTW
  } state_t;

  state_t         state;
  logic [VCW-1:0] vcount;
  logic [LCW-1:0] lcount;
  logic [VIW-1:0] cur_first;
  logic [VCW-1:0] cur_total;
  logic           cur_closed;

  pht_pkg::pt_t   qp;
  logic [14:0]    qpad;
  logic           in_poly;
  logic           any_seg;
  logic [pht_pkg::DSQ_W-1:0] best;
  logic [LCW-1:0] l;
  logic [VCW-1:0] k;
  logic [VIW-1:0] lp_first;
  logic [VCW-1:0] lp_n;
  logic           lp_cl;
  pht_pkg::pt_t   prev;
  pht_pkg::pt_t   cur;
  logic           seg_go;
  logic           root_go;

  logic           new_loop;
  logic           full;
  logic           add_ok;
  logic           lp_closing;
  logic [VCW-1:0] last_k;
  logic           at_last_k;
  logic           at_last_loop;
  logic [LCW-1:0] lcount_m1;
  pht_pkg::res_t  add_res;

  logic           vram_we;
  logic [VIW-1:0] vram_waddr;
  logic [31:0]    vram_wdata;
  logic [VIW-1:0] vram_raddr;
  logic [31:0]    vram_rdata;
  logic           lram_we;
  logic [LIW-1:0] lram_waddr;
  loop_ent_t      lram_wdata;
  loop_ent_t      lram_rdata;

  pht_pkg::seg_res_t          seg_res;
  logic                       root_done;
  logic [pht_pkg::ROOT_W-1:0] root;

  assign item_pop = (state == B_IDLE) && item_valid;

  assign new_loop  = item.starts || (lcount == '0);
  assign full      = (vcount == VCW'(MAX_VERTICES)) ||
                     (new_loop && (lcount == LCW'(MAX_LOOPS)));
  assign add_ok    = item_pop && (item.op == pht_pkg::OP_ADD) && !full;
  assign lcount_m1 = lcount - LCW'(1);

  always_comb begin
    add_res        = '0;
    add_res.status = full;
  end

  assign vram_we    = add_ok;
  assign vram_waddr = vcount[VIW-1:0];
  assign vram_wdata = {item.x, item.y};

  // The entry of the newest loop is rewritten on every add to it.
  always_comb begin
    lram_we = add_ok;
    if (new_loop) begin
      lram_waddr        = lcount[LIW-1:0];
      lram_wdata.first  = vcount[VIW-1:0];
      lram_wdata.total  = VCW'(1);
      lram_wdata.closed = item.closed;
    end else begin
      lram_waddr        = lcount_m1[LIW-1:0];
      lram_wdata.first  = cur_first;
      lram_wdata.total  = cur_total + VCW'(1);
      lram_wdata.closed = cur_closed;
    end
  end

  // The closing segment of a closed loop re-reads its first vertex.
  assign lp_closing   = lp_cl && (lp_n > VCW'(2));
  assign last_k       = lp_closing ? lp_n : lp_n - VCW'(1);
  assign at_last_k    = (k == last_k);
  assign at_last_loop = ((l + LCW'(1)) == lcount);
  assign vram_raddr   = (k == lp_n) ? lp_first : lp_first + k[VIW-1:0];

  pht_ram #(.WIDTH(32), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  pht_ram #(.WIDTH($bits(loop_ent_t)), .DEPTH(MAX_LOOPS)) u_lram (
    .clk   (clk),
    .we    (lram_we),
    .waddr (lram_waddr),
    .wdata (lram_wdata),
    .raddr (l[LIW-1:0]),
    .rdata (lram_rdata)
  );

  pht_seg u_seg (
    .clk (clk),
    .rst (rst),
    .go  (seg_go),
    .a   (prev),
    .b   (cur),
    .p   (qp),
    .res (seg_res)
  );

  pht_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .go    (root_go),
    .value (best),
    .done  (root_done),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= B_IDLE;
      vcount  <= '0;
      lcount  <= '0;
      done    <= 1'b0;
      seg_go  <= 1'b0;
      root_go <= 1'b0;
    end else begin
      done    <= 1'b0;
      seg_go  <= 1'b0;
      root_go <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (item_valid) begin
            unique case (item.op)
              pht_pkg::OP_CLEAR: begin
                result <= '0;
                vcount <= '0;
                lcount <= '0;
                done   <= 1'b1;
              end
              pht_pkg::OP_ADD: begin
                result <= add_res;
                if (!full) begin
                  vcount <= vcount + VCW'(1);
                  if (new_loop) begin
                    cur_first  <= vcount[VIW-1:0];
                    cur_total  <= VCW'(1);
                    cur_closed <= item.closed;
                    lcount     <= lcount + LCW'(1);
                  end else begin
                    cur_total <= cur_total + VCW'(1);
                  end
                end
                done <= 1'b1;
              end
              pht_pkg::OP_QUERY: begin
                qp.x    <= item.x;
                qp.y    <= item.y;
                qpad    <= item.pad;
                in_poly <= 1'b0;
                any_seg <= 1'b0;
                l       <= '0;
                state   <= (lcount == '0) ? B_ROOT : B_LREQ;
              end
              pht_pkg::OP_NOP: begin
                result <= '0;
                done   <= 1'b1;
              end
            endcase
          end
        end
        B_LREQ: begin
          state <= B_LGET;
        end
        B_LGET: begin
          lp_first <= lram_rdata.first;
          lp_n     <= lram_rdata.total;
          lp_cl    <= lram_rdata.closed;
          k        <= '0;
          if (lram_rdata.total < VCW'(2)) begin
            if (at_last_loop) begin
              state <= B_ROOT;
            end else begin
              l     <= l + LCW'(1);
              state <= B_LREQ;
            end
          end else begin
            state <= B_VREQ;
          end
        end
        B_VREQ: begin
          state <= B_VGET;
        end
        B_VGET: begin
          cur <= pht_pkg::pt_t'(vram_rdata);
          if (k == '0) begin
            prev  <= pht_pkg::pt_t'(vram_rdata);
            k     <= k + VCW'(1);
            state <= B_VREQ;
          end else begin
            seg_go <= 1'b1;
            state  <= B_SEGW;
          end
        end
        B_SEGW: begin
          if (seg_res.done) begin
            any_seg <= 1'b1;
            if (!any_seg || (seg_res.dsq < best)) begin
              best <= seg_res.dsq;
            end
            if (lp_closing && seg_res.toggle) begin
              in_poly <= !in_poly;
            end
            prev <= cur;
            if (!at_last_k) begin
              k     <= k + VCW'(1);
              state <= B_VREQ;
            end else if (at_last_loop) begin
              state <= B_ROOT;
            end else begin
              l     <= l + LCW'(1);
              state <= B_LREQ;
            end
          end
        end
        B_ROOT: begin
          if (any_seg) begin
            root_go <= 1'b1;
            state   <= B_ROOTW;
          end else begin
            result.status     <= 1'b0;
            result.inside_res <= in_poly;
            result.near       <= in_poly;
            result.distance   <= '0;
            result.no_outline <= 1'b1;
            done              <= 1'b1;
            state             <= B_IDLE;
          end
        end
        B_ROOTW: begin
          if (root_done) begin
            result.status     <= 1'b0;
            result.inside_res <= in_poly;
            result.near       <= in_poly ||
                                 ((qpad != 15'd0) && (root <= pht_pkg::ROOT_W'(qpad)));
            result.distance   <= (root > pht_pkg::ROOT_W'(pht_pkg::DIST_MAX)) ?
                                 pht_pkg::DIST_MAX : root[16:0];
            result.no_outline <= 1'b0;
            done              <= 1'b1;
            state             <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/polygon_hit_test_top.sv]
// ----------------------------------------------------------------------------
// polygon_hit_test_top: even-odd point in polygon with distance to outline
//
//   channel   ports                  beat taken when
//   command   start, busy, cmd       start high and busy low at a rising edge
//   result    done, result           done high, for exactly one cycle
//
// A clear, add or unused command gives its result in the cycle after it leaves
// the command queue. A query reads each loop entry and vertex, works each
// segment by clamped projection or by division, then takes the square root.
// A synchronous reset empties the table and the queue. The two entry queue
// takes commands while the walker is busy; busy rises when it is full.
// Results cannot be held off.
// ----------------------------------------------------------------------------
module polygon_hit_test_top #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_LOOPS    = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  pht_pkg::cmd_t  cmd,
  output logic           done,
  output pht_pkg::res_t  result
);

  logic           item_valid;
  logic           item_pop;
  pht_pkg::item_t item;

  pht_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  pht_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_LOOPS    (MAX_LOOPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .done       (done),
    .result     (result)
  );

endmodule

[hw/rtl/pht_checker.sv]
// ----------------------------------------------------------------------------
// pht_checker: port level checks of the polygon hit test block
// Consistency of the result fields that every result beat must keep.
// ----------------------------------------------------------------------------
module pht_checker (
  input logic          clk,
  input logic          rst,
  input logic          done,
  input pht_pkg::res_t result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (!result.inside_res && !result.near &&
      (result.distance == 17'd0) && !result.no_outline))
    else $error("table full beat carries query fields");

  a_no_outline: assert property (@(posedge clk) disable iff (rst)
    (done && result.no_outline) |->
      ((result.distance == 17'd0) && (result.near == result.inside_res)))
    else $error("empty outline beat has distance or stray near");

  a_inside_near: assert property (@(posedge clk) disable iff (rst)
    (done && result.inside_res) |-> result.near)
    else $error("inside point not flagged near");

endmodule

bind polygon_hit_test_top pht_checker u_pht_checker (
  .clk    (clk),
  .rst    (rst),
  .done   (done),
  .result (result)
);

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for the polygon hit test block
// Builds vertex tables of open and closed loops, queries points against them
// and checks every result beat against an in-bench predictor of containment,
// nearest-segment distance and the near flag.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT = 256;
  localparam int NLOOP = 16;
  localparam int WATCHDOG = 200000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pht_pkg::cmd_t cmd = '0;
  logic done;
  pht_pkg::res_t result;

  polygon_hit_test_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result)
  );

  always #1 clk = ~clk;

  // Predictor copy of the vertex table.
  logic signed [15:0] vx [NVERT];
  logic signed [15:0] vy [NVERT];
  int unsigned lp_first [NLOOP];
  int unsigned lp_total [NLOOP];
  bit lp_closed [NLOOP];
  int unsigned n_vert = 0;
  int unsigned n_loop = 0;

  pht_pkg::cmd_t pending_cmds[$];
  pht_pkg::res_t expected_res[$];
  int mismatches = 0;
  int n_results = 0;
  int idle_cnt = 0;
  bit burst_ok = 1'b1;
  bit hold_send = 1'b0;

  // busy_seen marks a beat taken at the last rising edge, so a new one may go.
  logic busy_seen = 1'b0;
  int quiet = 0;

  function automatic void queue_cmd(pht_pkg::cmd_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned seg_dsq(longint px, longint py, int ia, int ib);
    longint ax, ay, bx, by, abx, aby, len, num, qx, qy, dx, dy;
    ax = vx[ia]; ay = vy[ia]; bx = vx[ib]; by = vy[ib];
    abx = bx - ax; aby = by - ay;
    len = abx * abx + aby * aby;
    qx = ax; qy = ay;
    if (len != 0) begin
      num = (px - ax) * abx + (py - ay) * aby;
      if (num >= len) begin
        qx = bx; qy = by;
      end else if (num > 0) begin
        qx = ax + fdiv(abx * num, len);
        qy = ay + fdiv(aby * num, len);
      end
    end
    dx = px - qx; dy = py - qy;
    return longint'(dx * dx) + longint'(dy * dy);
  endfunction

  function automatic bit crosses(longint px, longint py, int ia, int ib);
    longint ax, ay, bx, by, d, lhs, rhs;
    ax = vx[ia]; ay = vy[ia]; bx = vx[ib]; by = vy[ib];
    if ((ay > py) == (by > py)) return 1'b0;
    d = by - ay;
    lhs = (px - ax) * d;
    rhs = (py - ay) * (bx - ax);
    return (d > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  // Applies one command to the table copy and returns the expected result.
  function automatic pht_pkg::res_t hit_test_predict(pht_pkg::cmd_t c);
    pht_pkg::res_t r;
    bit new_loop, ins, in_l, any_seg;
    longint unsigned best, d, root;
    int unsigned f, n, prv;
    r = '0;
    case (c.func)
      pht_pkg::FUNC_CLEAR: begin
        n_vert = 0;
        n_loop = 0;
      end
      pht_pkg::FUNC_ADD: begin
        new_loop = c.starts_loop || n_loop == 0;
        if (n_vert >= NVERT || (new_loop && n_loop >= NLOOP)) begin
          r.status = 1'b1;
        end else begin
          vx[n_vert] = c.coord_x;
          vy[n_vert] = c.coord_y;
          if (new_loop) begin
            lp_first[n_loop] = n_vert;
            lp_total[n_loop] = 1;
            lp_closed[n_loop] = c.loop_is_closed;
            n_loop++;
          end else begin
            lp_total[n_loop-1]++;
          end
          n_vert++;
        end
      end
      pht_pkg::FUNC_QUERY: begin
        ins = 0; any_seg = 0; best = 0;
        for (int l = 0; l < n_loop; l++) begin
          f = lp_first[l];
          n = lp_total[l];
          if (lp_closed[l] && n >= 3) begin
            in_l = 0;
            prv = n - 1;
            for (int k = 0; k < n; k++) begin
              if (crosses(c.coord_x, c.coord_y, f + k, f + prv)) in_l = !in_l;
              prv = k;
            end
            if (in_l) ins = !ins;
          end
          if (n >= 2) begin
            for (int k = 0; k + 1 < n; k++) begin
              d = seg_dsq(c.coord_x, c.coord_y, f + k, f + k + 1);
              if (!any_seg || d < best) best = d;
              any_seg = 1;
            end
            if (lp_closed[l] && n > 2) begin
              d = seg_dsq(c.coord_x, c.coord_y, f + n - 1, f);
              if (d < best) best = d;
            end
          end
        end
        r.inside_res = ins;
        if (any_seg) begin
          root = int_sqrt(best);
          r.distance = (root > 131071) ? pht_pkg::DIST_MAX : root[16:0];
          r.near = ins || (c.pad != 0 && root <= c.pad);
        end else begin
          r.no_outline = 1'b1;
          r.near = ins;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic pht_pkg::cmd_t mk(logic [1:0] f, int x, int y, bit s, bit cl, int p);
    pht_pkg::cmd_t c;
    c.func = f;
    c.coord_x = x[15:0];
    c.coord_y = y[15:0];
    c.starts_loop = s;
    c.loop_is_closed = cl;
    c.pad = p[14:0];
    return c;
  endfunction

  function automatic int rcoord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  function automatic pht_pkg::cmd_t rquery(int span);
    int p;
    p = ($urandom_range(3) == 0) ? 0 : $urandom_range(32767);
    if ($urandom_range(1)) p = $urandom_range(2 * span);
    return mk(pht_pkg::FUNC_QUERY, rcoord(span), rcoord(span), $urandom_range(1),
              $urandom_range(1), p);
  endfunction

  // Driver: sends the next command at a falling edge unless holding or idling.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy_seen) begin
      // Beat still waiting for acceptance; hold it.
    end else if (hold_send && expected_res.size() != 0) begin
      start <= 1'b0;
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      start <= 1'b0;
    end else if (burst_ok && $urandom_range(9) == 0) begin
      idle_cnt <= $urandom_range(6);
      start <= 1'b0;
    end else if (pending_cmds.size() != 0) begin
      cmd <= pending_cmds.pop_front();
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  always @(posedge clk) begin
    busy_seen <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        expected_res = {expected_res, hit_test_predict(cmd)};
        busy_seen <= 1'b1;
      end
      if (done) begin
        n_results++;
        if (expected_res.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", result);
        end else begin
          pht_pkg::res_t e;
          e = expected_res.pop_front();
          if (result.status !== e.status || result.inside_res !== e.inside_res ||
              result.near !== e.near || result.distance !== e.distance ||
              result.no_outline !== e.no_outline) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: expected %p, got %p", n_results, e, result);
          end
        end
      end
      if ((start && !busy) || done) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || start || expected_res.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int span, nv, nl;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty table, unused command, extremes, a square, a degenerate segment.
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 0, 0, 0, 0, 100));
    queue_cmd(mk(FUNC_UNUSED, -1, -1, 1, 1, 32767));
    queue_cmd(mk(pht_pkg::FUNC_ADD, -32768, -32768, 0, 1, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 32767, 32767, 0, 0, 32767));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 32767, 32767, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 32767, -32768, 0, 0, 1));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 32767, 32767, 1, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 32767, 32767, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, -32768, 32767, 1, 1, 32767));
    queue_cmd(mk(pht_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, -160, -160, 1, 1, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 160, -160, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 160, 160, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, -160, 160, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 0, 0, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 160, 0, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 200, 0, 0, 0, 40));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 200, 0, 0, 0, 39));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 0, -160, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 5, 5, 1, 1, 0));
    queue_cmd(mk(pht_pkg::FUNC_ADD, 5, 5, 0, 0, 0));
    queue_cmd(mk(pht_pkg::FUNC_QUERY, 9, 8, 0, 0, 5));
    wait_drained();

    // Fill the loop table, then the vertex table, to reach the full status.
    hold_send = 1'b1;
    queue_cmd(mk(pht_pkg::FUNC_CLEAR, 0, 0, 0, 0, 0));
    for (int i = 0; i < 17; i++)
      queue_cmd(mk(pht_pkg::FUNC_ADD, rcoord(2000), rcoord(2000), 1,
                   $urandom_range(1), 0));
    for (int i = 0; i < 241; i++)
      queue_cmd(mk(pht_pkg::FUNC_ADD, rcoord(2000), rcoord(2000), 0, 0, 0));
    queue_cmd(rquery(2000));
    wait_drained();
    hold_send = 1'b0;

    // Random: mostly small well-formed loop sets with queries, some noise.
    for (int set = 0; set < 85; set++) begin
      span = (set % 10 == 0) ? 32768 : 64 << $urandom_range(8);
      if (span > 32768) span = 32768;
      queue_cmd(mk(pht_pkg::FUNC_CLEAR, rcoord(span), rcoord(span),
                   $urandom_range(1), $urandom_range(1), $urandom_range(32767)));
      nl = $urandom_range(1, 4);
      for (int l = 0; l < nl; l++) begin
        nv = $urandom_range(1, 6);
        for (int k = 0; k < nv; k++)
          queue_cmd(mk(pht_pkg::FUNC_ADD, rcoord(span), rcoord(span), k == 0,
                       ($urandom_range(3) != 0), $urandom_range(32767)));
        if ($urandom_range(7) == 0) queue_cmd(rquery(span));
      end
      for (int q = 0; q < 5; q++) begin
        if ($urandom_range(15) == 0) queue_cmd(mk(FUNC_UNUSED,
            rcoord(span), rcoord(span), 1, 1, 5));
        queue_cmd(rquery(span));
      end
      if (set == 50) begin
        wait_drained();
        hold_send = 1'b1;
        queue_cmd(rquery(span));
        wait_drained();
        hold_send = 1'b0;
      end
      if (set == 70) burst_ok = 1'b0;
      while (pending_cmds.size() > 8) @(posedge clk);
    end
    wait_drained();
    repeat (50) @(posedge clk);

    $display("Covered %0d result beats: loop sets of one to four loops, full tables,",
             n_results);
    $display("degenerate segments and full-range coordinates; %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
